/* hw/rtl/raster_tile_cache_lru_core_defines.svh */
// Assertion macros shared by the raster tile cache RTL.
`ifndef RASTER_TILE_CACHE_LRU_CORE_DEFINES_SVH
`define RASTER_TILE_CACHE_LRU_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define RTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define RTC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RTC_ASSERT(lbl, clk, rst_n, prop, msg)

`define RTC_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

/* hw/rtl/rtc_pkg.sv */
// Types and constants of the raster tile cache.
package rtc_pkg;

  localparam int RTC_MAX_TILES = 16;

  localparam int PIX_W   = 16;
  localparam int TSIZE_W = 13;
  localparam int TNUM_W  = 32;
  localparam int STAMP_W = 48;
  localparam int OFS_W   = 24;
  localparam int SLOT_W  = 4;
  localparam int LIM_W   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS  = PIX_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RASTER_WIDTH   = 3'd0,
    CFG_RASTER_HEIGHT  = 3'd1,
    CFG_TILE_WIDTH     = 3'd2,
    CFG_TILE_HEIGHT    = 3'd3,
    CFG_TILES_ACROSS   = 3'd4,
    CFG_RESIDENT_LIMIT = 3'd5
  } rtc_cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_CLIP,
    ST_MUL_NUM,
    ST_MUL_OFS,
    ST_SUM,
    ST_SCAN,
    ST_DECIDE,
    ST_WRITE,
    ST_DONE
  } rtc_state_e;

  typedef struct packed {
    logic [PIX_W-1:0]   quot;
    logic [TSIZE_W-1:0] rem;
  } rtc_div_res_t;

endpackage

/* hw/rtl/rtc_ram.sv */
// Generic single write port, single read port RAM with registered read.
module rtc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rtc_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module rtc_div
  import rtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [PIX_W-1:0]   dividend_i,
  input  logic [TSIZE_W-1:0] divisor_i,
  output logic               done_o,
  output rtc_div_res_t       res_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [PIX_W-1:0]     dq_q;
  logic [TSIZE_W-1:0]   rem_q;
  logic [TSIZE_W-1:0]   dvs_q;
  logic [TSIZE_W:0]     shifted;
  logic                 ge;
  logic [TSIZE_W:0]     diff;

  assign shifted = {rem_q, dq_q[PIX_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[PIX_W-2:0], ge};
      rem_q <= ge ? diff[TSIZE_W-1:0] : shifted[TSIZE_W-1:0];
    end
  end

  assign done_o   = done_q;
  assign res_o.quot = dq_q;
  assign res_o.rem  = rem_q;

endmodule

/* hw/rtl/raster_tile_cache_lru_core.sv */
// Top level of the raster tile cache: sequencer, resident-tile table and LRU scan.
//
// Usage: write the raster and tile geometry over the cfg channel (index plus data,
// always ready) while no word is in flight. Each input word on in_valid_i/in_ready_o
// carries one pixel coordinate; one result word leaves on out_valid_o/out_ready_i.
// A word is worked on alone: in_ready_o is high only while the sequencer is idle.
// From acceptance to out_valid_o the word goes through two passes of the shared
// bit-serial divider (tile column and row), a clip step, two steps on the shared
// 16x16 multiplier, a sum step, a pass over the table reading one entry a cycle
// from the tag and stamp memories, then a decision, a write-back and a hand-off.
// A pixel outside the raster goes from the idle state through the done state to the
// output register, skipping the divider and the table, and leaves the table untouched.
// Reset clears the occupancy bits, the use clock and the output valid flag; the
// geometry registers take their defaults. Tag and stamp memories need no clearing.
// When the receiver stalls, the result holds in the output register; the block
// still accepts the next word and works on it, then waits to hand its result over.
`include "raster_tile_cache_lru_core_defines.svh"

module raster_tile_cache_lru_core
  import rtc_pkg::*;
#(
  parameter int MAX_TILES = RTC_MAX_TILES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_x_i,
  input  logic [PIX_W-1:0]      pixel_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_of_range_o,
  output logic                  hit_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic [TNUM_W-1:0]     tile_number_o,
  output logic                  evicted_o,
  output logic [TNUM_W-1:0]     evicted_tile_o,
  output logic [PIX_W-1:0]      tile_origin_x_o,
  output logic [PIX_W-1:0]      tile_origin_y_o,
  output logic [TSIZE_W-1:0]    tile_cols_o,
  output logic [TSIZE_W-1:0]    tile_rows_o,
  output logic [OFS_W-1:0]      pixel_offset_o
);

  localparam int IDX_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CNT_W = $clog2(MAX_TILES + 1);
  localparam int LW    = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  // configuration
  logic [PIX_W-1:0]   rw_q, rh_q, ta_q;
  logic [TSIZE_W-1:0] tw_q, th_q;
  logic [LIM_W-1:0]   rl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_q <= PIX_W'(65535);
      rh_q <= PIX_W'(65535);
      tw_q <= TSIZE_W'(256);
      th_q <= TSIZE_W'(256);
      ta_q <= PIX_W'(256);
      rl_q <= LIM_W'(16);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RASTER_WIDTH:   rw_q <= cfg_data_i;
        CFG_RASTER_HEIGHT:  rh_q <= cfg_data_i;
        CFG_TILE_WIDTH:     tw_q <= cfg_data_i[TSIZE_W-1:0];
        CFG_TILE_HEIGHT:    th_q <= cfg_data_i[TSIZE_W-1:0];
        CFG_TILES_ACROSS:   ta_q <= cfg_data_i;
        CFG_RESIDENT_LIMIT: rl_q <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [TSIZE_W-1:0] twe, the;
  logic [LW-1:0]      lim_raw, lim;

  assign twe     = (tw_q == '0) ? TSIZE_W'(1) : tw_q;
  assign the     = (th_q == '0) ? TSIZE_W'(1) : th_q;
  assign lim_raw = LW'(rl_q);

  always_comb begin
    lim = lim_raw;
    if (lim_raw == '0) begin
      lim = LW'(1);
    end else if (lim_raw > LW'(MAX_TILES)) begin
      lim = LW'(MAX_TILES);
    end
  end

  logic [PIX_W-1:0]    px_q, py_q, tx_q, ty_q;
  logic [TSIZE_W-1:0]  rx_q, ry_q;
  logic [PIX_W-1:0]    ox_q, oy_q;
  logic [TSIZE_W-1:0]  cols_q, rows_q;
  logic                oor_q;
  logic [TNUM_W-1:0]   tnum_q;
  logic [OFS_W-1:0]    ofs_q;
  logic [2*PIX_W-1:0]  prod_q;
  logic [PIX_W-1:0]    mul_a, mul_b;
  logic [PIX_W-1:0]    ox_w, oy_w, xspan, yspan;

  // sequencer
  rtc_state_e state_q, state_d;
  logic       in_acc, oor_in, load_out;
  logic       div_start, div_done;
  logic [PIX_W-1:0]   div_dividend;
  logic [TSIZE_W-1:0] div_divisor;
  rtc_div_res_t       div_res;

  logic [CNT_W-1:0] cnt_q;
  logic             pend_q;
  logic [IDX_W-1:0] pidx_q;
  logic             scan_end;
  logic             out_valid_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign oor_in     = (pixel_x_i >= rw_q) || (pixel_y_i >= rh_q);
  assign scan_end   = (cnt_q == CNT_W'(MAX_TILES));
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = pixel_x_i;
    div_divisor  = twe;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (oor_in) begin
            state_d = ST_DONE;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIVX;
          end
        end
      end
      ST_DIVX: begin
        div_dividend = py_q;
        div_divisor  = the;
        if (div_done) begin
          div_start = 1'b1;
          state_d   = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_done) begin
          state_d = ST_CLIP;
        end
      end
      ST_CLIP:    state_d = ST_MUL_NUM;
      ST_MUL_NUM: state_d = ST_MUL_OFS;
      ST_MUL_OFS: state_d = ST_SUM;
      ST_SUM:     state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE:  state_d = ST_WRITE;
      ST_WRITE:   state_d = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  rtc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // geometry datapath
  assign ox_w  = px_q - PIX_W'(rx_q);
  assign oy_w  = py_q - PIX_W'(ry_q);
  assign xspan = rw_q - ox_w;
  assign yspan = rh_q - oy_w;
  assign mul_a = (state_q == ST_MUL_NUM) ? ty_q : PIX_W'(ry_q);
  assign mul_b = (state_q == ST_MUL_NUM) ? ta_q : PIX_W'(cols_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q  <= pixel_x_i;
      py_q  <= pixel_y_i;
      oor_q <= oor_in;
    end
    if ((state_q == ST_DIVX) && div_done) begin
      tx_q <= div_res.quot;
      rx_q <= div_res.rem;
    end
    if ((state_q == ST_DIVY) && div_done) begin
      ty_q <= div_res.quot;
      ry_q <= div_res.rem;
    end
    if (state_q == ST_CLIP) begin
      ox_q   <= ox_w;
      oy_q   <= oy_w;
      cols_q <= (xspan < PIX_W'(twe)) ? xspan[TSIZE_W-1:0] : twe;
      rows_q <= (yspan < PIX_W'(the)) ? yspan[TSIZE_W-1:0] : the;
    end
    if ((state_q == ST_MUL_NUM) || (state_q == ST_MUL_OFS)) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == ST_MUL_OFS) begin
      tnum_q <= TNUM_W'(tx_q) + prod_q;
    end
    if (state_q == ST_SUM) begin
      ofs_q <= OFS_W'(rx_q) + prod_q[OFS_W-1:0];
    end
  end

  // resident-tile table
  logic [MAX_TILES-1:0] valid_q;
  logic [STAMP_W-1:0]   use_clock_q, stamp_new;
  logic [TNUM_W-1:0]    tag_rd;
  logic [STAMP_W-1:0]   stamp_rd;
  logic [IDX_W-1:0]     raddr;
  logic                 wr_en;

  assign raddr     = cnt_q[IDX_W-1:0];
  assign wr_en     = (state_q == ST_WRITE);
  assign stamp_new = use_clock_q + STAMP_W'(1);

  logic             hit_q, ev_q, free_found_q, vic_found_q;
  logic [IDX_W-1:0] hslot_q, free_slot_q, vic_slot_q, slot_q;
  logic [CNT_W-1:0] count_q;
  logic [STAMP_W-1:0] vic_stamp_q;
  logic [TNUM_W-1:0]  vic_tag_q, evtag_q;

  rtc_ram #(
    .WIDTH (TNUM_W),
    .DEPTH (MAX_TILES),
    .AW    (IDX_W)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en && !hit_q),
    .waddr_i (slot_q),
    .wdata_i (tnum_q),
    .raddr_i (raddr),
    .rdata_o (tag_rd)
  );

  rtc_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (MAX_TILES),
    .AW    (IDX_W)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (slot_q),
    .wdata_i (stamp_new),
    .raddr_i (raddr),
    .rdata_o (stamp_rd)
  );

  logic ent_valid, vic_take;

  assign ent_valid = pend_q && valid_q[pidx_q];
  assign vic_take  = !vic_found_q || (stamp_rd < vic_stamp_q)
                     || ((stamp_rd == vic_stamp_q) && (tag_rd < vic_tag_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      use_clock_q <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
    end else begin
      if (state_q == ST_SUM) begin
        cnt_q  <= '0;
        pend_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (scan_end) begin
          pend_q <= 1'b0;
        end else begin
          pend_q <= 1'b1;
          cnt_q  <= cnt_q + 1'b1;
        end
      end
      if (wr_en) begin
        valid_q[slot_q] <= 1'b1;
        use_clock_q     <= stamp_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      vic_found_q  <= 1'b0;
      count_q      <= '0;
    end else if (state_q == ST_SCAN) begin
      pidx_q <= raddr;
      if (ent_valid) begin
        count_q <= count_q + 1'b1;
        if (!hit_q && (tag_rd == tnum_q)) begin
          hit_q   <= 1'b1;
          hslot_q <= pidx_q;
        end
        if (vic_take) begin
          vic_found_q <= 1'b1;
          vic_slot_q  <= pidx_q;
          vic_stamp_q <= stamp_rd;
          vic_tag_q   <= tag_rd;
        end
      end else if (pend_q && !free_found_q) begin
        free_found_q <= 1'b1;
        free_slot_q  <= pidx_q;
      end
    end
    if (state_q == ST_DECIDE) begin
      ev_q    <= 1'b0;
      evtag_q <= '0;
      if (hit_q) begin
        slot_q <= hslot_q;
      end else if (LW'(count_q) >= lim) begin
        slot_q  <= vic_slot_q;
        ev_q    <= 1'b1;
        evtag_q <= vic_tag_q;
      end else begin
        slot_q <= free_slot_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_of_range_o  <= oor_q;
      hit_o           <= !oor_q && hit_q;
      slot_o          <= oor_q ? '0 : SLOT_W'(slot_q);
      tile_number_o   <= oor_q ? '0 : tnum_q;
      evicted_o       <= !oor_q && !hit_q && ev_q;
      evicted_tile_o  <= (oor_q || hit_q) ? '0 : evtag_q;
      tile_origin_x_o <= oor_q ? '0 : ox_q;
      tile_origin_y_o <= oor_q ? '0 : oy_q;
      tile_cols_o     <= oor_q ? '0 : cols_q;
      tile_rows_o     <= oor_q ? '0 : rows_q;
      pixel_offset_o  <= oor_q ? '0 : ofs_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `RTC_ASSERT(a_hit_no_evict, clk_i, rst_ni, out_valid_o |-> !(hit_o && evicted_o), "hit with eviction")
  `RTC_ASSERT(a_oor_quiet, clk_i, rst_ni, (out_valid_o && out_of_range_o) |-> (!hit_o && !evicted_o), "out of range result carries table fields")
  `RTC_ASSERT(a_div_done_state, clk_i, rst_ni, div_done |-> ((state_q == ST_DIVX) || (state_q == ST_DIVY)), "divider done outside divide states")
  `RTC_ASSERT(a_write_sets_valid, clk_i, rst_ni, wr_en |=> valid_q[$past(slot_q)], "written slot not marked valid")
  `RTC_ASSERT(a_clock_stable, clk_i, rst_ni, !wr_en |=> $stable(use_clock_q), "use clock moved without a write")

endmodule
